// File: src/assert_macros.svh
// Assertion helper macros shared by the linked-list engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PLLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define PLLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/plle_pkg.sv
// Shared types and codes of the pooled linked-list engine.
`timescale 1ns / 1ps
`default_nettype none
package plle_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = 2;

   localparam int HEAD_NODE   = 0;
   localparam int TAIL_NODE   = 1;
   localparam int FIRST_FREE  = 2;

   localparam logic [1:0] OP_PUSH_BACK = 2'd0;
   localparam logic [1:0] OP_INSERT    = 2'd1;
   localparam logic [1:0] OP_REMOVE    = 2'd2;
   localparam logic [1:0] OP_DUMP      = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef enum logic [3:0] {
      KIND_PUSH   = 4'b0001,
      KIND_INSERT = 4'b0010,
      KIND_REMOVE = 4'b0100,
      KIND_DUMP   = 4'b1000
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
      logic [3:0]         position;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [3:0]         element_count;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// File: src/plle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module plle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/plle_front.sv
// Front end: accept request beats, classify the opcode, queue commands.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module plle_front
   import plle_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        q_valid,
   output cmd_type                     q_cmd,
   input  wire logic                   q_pop
);

   localparam int QD  = 2;
   localparam int QAW = $clog2(QD);

   cmd_type        slot_ff [QD];
   logic [QAW-1:0] wptr_ff, wptr_in;
   logic [QAW-1:0] rptr_ff, rptr_in;
   logic [QAW:0]   count_ff, count_in;
   logic           push;
   cmd_type        cmd;

   // Classify the opcode into a one-hot command kind.
   always_comb begin
      cmd.value    = req_tdata[33:2];
      cmd.position = req_tdata[37:34];
      case (req_tdata[1:0])
         OP_PUSH_BACK: cmd.kind = KIND_PUSH;
         OP_INSERT:    cmd.kind = KIND_INSERT;
         OP_REMOVE:    cmd.kind = KIND_REMOVE;
         OP_DUMP:      cmd.kind = KIND_DUMP;
         default:      cmd.kind = KIND_DUMP;
      endcase
   end

   assign req_tready = enable && (count_ff != (QAW+1)'(QD));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_cmd      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push  ? QAW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = q_pop ? QAW'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= cmd;
      end
   end

   `PLLE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= (QAW+1)'(QD), "queue overfilled")
   `PLLE_ASSERT_NEXT(a_count_up, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise")
   `PLLE_ASSERT_NEXT(a_count_down, clock, reset, q_pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count did not fall")

endmodule
`default_nettype wire

// File: src/plle_back.sv
// Back end: link walker, free-node scan, list update and dump sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module plle_back
   import plle_pkg::*;
#(
   parameter int POOL_NODES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         clearing,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output rsp_type      rsp
);

   localparam int IDXW = $clog2(POOL_NODES);
   localparam int MW   = IDXW + 1;
   localparam int CMPW = (IDXW > 4) ? IDXW : 4;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_WALK  = 8'b00000100,
      S_SCAN  = 8'b00001000,
      S_LINK  = 8'b00010000,
      S_FREE  = 8'b00100000,
      S_DUMP  = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   state_type       state_ff, state_in;
   logic [IDXW-1:0] len_ff, len_in;
   logic [IDXW-1:0] cur_ff, cur_in;
   logic [IDXW-1:0] prv_ff, prv_in;
   logic [IDXW-1:0] nxt_ff, nxt_in;
   logic [IDXW-1:0] fre_ff, fre_in;
   logic [IDXW-1:0] rem_ff, rem_in;
   logic [IDXW-1:0] sc_ff, sc_in;
   logic [1:0]      st_ff, st_in;
   cmd_type         cmd_ff, cmd_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            mw_en;
   logic [IDXW-1:0] mw_addr;
   logic [MW-1:0]   mw_data;
   logic [MW-1:0]   mrd_data;
   logic            vw_en;
   logic [31:0]     vrd_data;
   logic [IDXW-1:0] ra;
   logic [IDXW-1:0] mrd_link;
   logic            mrd_busy;
   logic            out_free;
   logic            full;
   logic [CMPW-1:0] pos_x;
   logic [CMPW-1:0] len_x;

   // Link word per node: busy flag above the index of the next node.
   plle_ram #(.WIDTH(MW), .DEPTH(POOL_NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (mw_en),
      .wr_addr (mw_addr),
      .wr_data (mw_data),
      .rd_addr (ra),
      .rd_data (mrd_data)
   );

   plle_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_value_ram (
      .clock   (clock),
      .wr_en   (vw_en),
      .wr_addr (sc_ff),
      .wr_data (cmd_ff.value),
      .rd_addr (ra),
      .rd_data (vrd_data)
   );

   assign mrd_link   = mrd_data[IDXW-1:0];
   assign mrd_busy   = mrd_data[IDXW];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (len_ff == IDXW'(POOL_NODES - 2));
   assign pos_x      = CMPW'(q_cmd.position);
   assign len_x      = CMPW'(len_ff);
   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      prv_in       = prv_ff;
      nxt_in       = nxt_ff;
      fre_in       = fre_ff;
      rem_in       = rem_ff;
      sc_in        = sc_ff;
      st_in        = st_ff;
      cmd_in       = cmd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mw_en        = 1'b0;
      mw_addr      = cur_ff;
      mw_data      = '0;
      vw_en        = 1'b0;
      ra           = cur_ff;
      q_pop        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // Initialize one link word per cycle: head points at tail.
            mw_en   = 1'b1;
            mw_addr = sc_ff;
            if (sc_ff == IDXW'(HEAD_NODE)) begin
               mw_data = {1'b1, IDXW'(TAIL_NODE)};
            end else if (sc_ff == IDXW'(TAIL_NODE)) begin
               mw_data = {1'b1, IDXW'(0)};
            end
            if (sc_ff == IDXW'(POOL_NODES - 1)) begin
               sc_in    = '0;
               state_in = S_IDLE;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         S_IDLE: begin
            ra     = IDXW'(HEAD_NODE);
            cur_in = IDXW'(HEAD_NODE);
            prv_in = IDXW'(HEAD_NODE);
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_WALK;
               case (q_cmd.kind)
                  KIND_PUSH: begin
                     rem_in = len_ff;
                     if (full) begin
                        st_in    = ST_FULL;
                        state_in = S_RESP;
                     end
                  end
                  KIND_INSERT: begin
                     rem_in = IDXW'(pos_x);
                     if (pos_x > len_x) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end else if (full) begin
                        st_in    = ST_FULL;
                        state_in = S_RESP;
                     end
                  end
                  KIND_REMOVE: begin
                     // Walk one past the predecessor to land on the victim.
                     rem_in = IDXW'(pos_x + CMPW'(1));
                     if (pos_x >= len_x) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end
                  end
                  KIND_DUMP: begin
                     rem_in = '0;
                     if (len_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     st_in    = ST_OK;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_WALK: begin
            // Read data holds the link word of cur_ff.
            if (rem_ff != '0) begin
               prv_in = cur_ff;
               cur_in = mrd_link;
               ra     = mrd_link;
               rem_in = rem_ff - 1'b1;
            end else if (cmd_ff.kind inside {KIND_PUSH, KIND_INSERT}) begin
               nxt_in   = mrd_link;
               sc_in    = IDXW'(FIRST_FREE);
               ra       = IDXW'(FIRST_FREE);
               state_in = S_SCAN;
            end else if (cmd_ff.kind == KIND_REMOVE) begin
               mw_en    = 1'b1;
               mw_addr  = prv_ff;
               mw_data  = {1'b1, mrd_link};
               state_in = S_FREE;
            end else begin
               cur_in   = mrd_link;
               ra       = mrd_link;
               rem_in   = len_ff - 1'b1;
               state_in = S_DUMP;
            end
         end
         S_SCAN: begin
            if (!mrd_busy) begin
               mw_en    = 1'b1;
               mw_addr  = sc_ff;
               mw_data  = {1'b1, nxt_ff};
               vw_en    = 1'b1;
               fre_in   = sc_ff;
               state_in = S_LINK;
            end else begin
               sc_in = sc_ff + 1'b1;
               ra    = sc_ff + 1'b1;
            end
         end
         S_LINK: begin
            mw_en    = 1'b1;
            mw_addr  = cur_ff;
            mw_data  = {1'b1, fre_ff};
            len_in   = len_ff + 1'b1;
            st_in    = ST_OK;
            state_in = S_RESP;
         end
         S_FREE: begin
            mw_en    = 1'b1;
            mw_addr  = cur_ff;
            mw_data  = '0;
            len_in   = len_ff - 1'b1;
            st_in    = ST_OK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = st_ff;
               rsp_in.element       = '0;
               rsp_in.element_count = len_x[3:0];
               rsp_in.last          = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_DUMP: begin
            // On a stall keep re-reading cur_ff so the read data holds.
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = ST_OK;
               rsp_in.element       = vrd_data;
               rsp_in.element_count = len_x[3:0];
               rsp_in.last          = (rem_ff == '0);
               if (rem_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in = mrd_link;
                  ra     = mrd_link;
                  rem_in = rem_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         len_ff       <= '0;
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         sc_ff        <= sc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      prv_ff <= prv_in;
      nxt_ff <= nxt_in;
      fre_ff <= fre_in;
      rem_ff <= rem_in;
      st_ff  <= st_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   `PLLE_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, len_ff <= IDXW'(POOL_NODES - 2), "list longer than pool allows")
   `PLLE_ASSERT_NEXT(a_link_grows, clock, reset, state_ff == S_LINK, len_ff == $past(len_ff) + 1'b1, "insert did not grow list")
   `PLLE_ASSERT_SAME(a_pop_idle, clock, reset, q_pop, state_ff == S_IDLE, "command taken while busy")

endmodule
`default_nettype wire

// File: src/pooled_linked_list_engine_unit.sv
// Top level of the pooled linked-list engine.
// The engine keeps an ordered list of signed 32-bit values in a pool of
// POOL_NODES nodes; nodes 0 and 1 are permanent head and tail sentinels, so
// the list holds at most POOL_NODES-2 elements. Each request beat carries
// opcode, value and position: push back, insert after position (0 is the
// front, position may equal the count), remove at position, or dump. Push,
// insert and remove answer with one beat; dump answers with one beat per
// element in list order (tlast on the final one), or a single list-empty beat.
// After reset a clearing pass initializes every link word; no request is taken
// during it. An accepted beat is registered in the command queue, then the
// sequencer works on it one state per cycle while its result is not stalled:
// push back and insert walk p links from the head (the count for push back,
// the position for insert), skip the busy nodes while looking for the lowest
// free node, then link the new node and answer; remove walks p = position + 1
// links, then unlinks and frees the node; a request rejected for range or a
// full pool, or a dump of an empty list, is answered without a walk. The walk
// and the scan share the single read port of the link memory, one node per
// cycle. A dump walks from the head to the first node, then streams one
// element per cycle. A stalled result holds the sequencer until the beat
// leaves. A two-entry command queue in front and a result register at the
// output let requests and results flow independently of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module pooled_linked_list_engine_unit
   import plle_pkg::*;
#(
   parameter int POOL_NODES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // opcode[1:0], value[33:2], position[37:34], zero pad[39:38]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status[1:0], element[33:2], element_count[37:34], zero pad[39:38]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast
);

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;
   logic    clearing;
   rsp_type rsp;

   // Accept beats and classify them; hold off while the pool is initialized.
   plle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (!clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   // Walk the links, update the pool and produce result beats.
   plle_back #(.POOL_NODES(POOL_NODES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.element_count, rsp.element, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule
`default_nettype wire
